// File: hdl/view_frustum_cull_test_macros.svh
// Assertion macros shared by the view frustum culling block.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef VIEW_FRUSTUM_CULL_TEST_MACROS_SVH
`define VIEW_FRUSTUM_CULL_TEST_MACROS_SVH

// Same-cycle implication, checked outside reset
`define VFC_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("vfc same-cycle check failed");

// Next-cycle implication, checked outside reset
`define VFC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("vfc next-cycle check failed");

`endif

// File: hdl/vfc_pkg.sv
// Shared types and constants for the view frustum culling block.
// No dependencies; used by vfc_ctrl, vfc_dp and the top level.
`default_nettype none

package vfc_pkg;

   localparam int PLANE_COUNT = 6;
   localparam int SQRT_STEPS  = 32;
   localparam int DIV_STEPS   = 49;

   localparam logic [1:0] MODE_LOAD   = 2'd0;
   localparam logic [1:0] MODE_BUILD  = 2'd1;
   localparam logic [1:0] MODE_SPHERE = 2'd2;
   localparam logic [1:0] MODE_BOX    = 2'd3;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LOAD,
      ST_RAW,
      ST_SQ,
      ST_SQI,
      ST_SQRT,
      ST_DIVI,
      ST_DIV,
      ST_DSTORE,
      ST_ZSTORE,
      ST_TMUL,
      ST_TACC,
      ST_DONE
   } state_type;

   typedef enum logic [3:0] {
      OP_NOP,
      OP_CAPTURE,
      OP_LOAD,
      OP_RAW,
      OP_SQ,
      OP_SQI,
      OP_SQRT,
      OP_DIVI,
      OP_DIV,
      OP_DSTORE,
      OP_ZSTORE,
      OP_TMUL,
      OP_TACC
   } dp_op_type;

   typedef struct packed {
      dp_op_type  op;
      logic [2:0] plane;
      logic [1:0] comp;
   } dp_cmd_type;

   typedef struct packed {
      logic len_zero;
   } dp_stat_type;

endpackage

`default_nettype wire

// File: hdl/vfc_ctrl.sv
// Sequencer for the view frustum culling block: handshake, plane and
// component counters, iteration counts. Depends on vfc_pkg and the macro header.
`default_nettype none
`include "view_frustum_cull_test_macros.svh"

module vfc_ctrl (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  start,
   input  wire  [1:0]           req_mode,
   input  vfc_pkg::dp_stat_type stat,
   output logic                 busy,
   output logic                 rsp_valid,
   output vfc_pkg::dp_cmd_type  cmd
);

   vfc_pkg::state_type state_ff, state_in;
   logic [1:0] mode_ff, mode_in;
   logic [2:0] k_ff, k_in;
   logic [1:0] c_ff, c_in;
   logic [5:0] it_ff, it_in;
   logic       accept;
   logic       last_plane;

   assign accept     = start && !busy;
   assign last_plane = (k_ff == 3'(vfc_pkg::PLANE_COUNT - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= vfc_pkg::ST_IDLE;
         mode_ff  <= vfc_pkg::MODE_LOAD;
         k_ff     <= '0;
         c_ff     <= '0;
         it_ff    <= '0;
      end else begin
         state_ff <= state_in;
         mode_ff  <= mode_in;
         k_ff     <= k_in;
         c_ff     <= c_in;
         it_ff    <= it_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         vfc_pkg::ST_IDLE: begin
            if (start) begin
               case (req_mode)
                  vfc_pkg::MODE_LOAD:  state_in = vfc_pkg::ST_LOAD;
                  vfc_pkg::MODE_BUILD: state_in = vfc_pkg::ST_RAW;
                  default:             state_in = vfc_pkg::ST_TMUL;
               endcase
            end
         end
         vfc_pkg::ST_LOAD:  state_in = vfc_pkg::ST_DONE;
         vfc_pkg::ST_RAW:   state_in = vfc_pkg::ST_SQ;
         vfc_pkg::ST_SQ:    if (c_ff == 2'd2) state_in = vfc_pkg::ST_SQI;
         vfc_pkg::ST_SQI:   state_in = vfc_pkg::ST_SQRT;
         vfc_pkg::ST_SQRT: begin
            if (it_ff == 6'(vfc_pkg::SQRT_STEPS - 1)) state_in = vfc_pkg::ST_DIVI;
         end
         vfc_pkg::ST_DIVI: begin
            state_in = stat.len_zero ? vfc_pkg::ST_ZSTORE : vfc_pkg::ST_DIV;
         end
         vfc_pkg::ST_DIV: begin
            if (it_ff == 6'(vfc_pkg::DIV_STEPS - 1)) state_in = vfc_pkg::ST_DSTORE;
         end
         vfc_pkg::ST_DSTORE: begin
            if (c_ff != 2'd3)    state_in = vfc_pkg::ST_DIVI;
            else if (last_plane) state_in = vfc_pkg::ST_DONE;
            else                 state_in = vfc_pkg::ST_RAW;
         end
         vfc_pkg::ST_ZSTORE: state_in = last_plane ? vfc_pkg::ST_DONE : vfc_pkg::ST_RAW;
         vfc_pkg::ST_TMUL:   state_in = vfc_pkg::ST_TACC;
         vfc_pkg::ST_TACC:   state_in = last_plane ? vfc_pkg::ST_DONE : vfc_pkg::ST_TMUL;
         vfc_pkg::ST_DONE:   state_in = vfc_pkg::ST_IDLE;
         default:            state_in = vfc_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      busy      = (state_ff != vfc_pkg::ST_IDLE);
      rsp_valid = (state_ff == vfc_pkg::ST_DONE);
      cmd.plane = k_ff;
      cmd.comp  = c_ff;
      case (state_ff)
         vfc_pkg::ST_IDLE:   cmd.op = start ? vfc_pkg::OP_CAPTURE : vfc_pkg::OP_NOP;
         vfc_pkg::ST_LOAD:   cmd.op = vfc_pkg::OP_LOAD;
         vfc_pkg::ST_RAW:    cmd.op = vfc_pkg::OP_RAW;
         vfc_pkg::ST_SQ:     cmd.op = vfc_pkg::OP_SQ;
         vfc_pkg::ST_SQI:    cmd.op = vfc_pkg::OP_SQI;
         vfc_pkg::ST_SQRT:   cmd.op = vfc_pkg::OP_SQRT;
         vfc_pkg::ST_DIVI:   cmd.op = vfc_pkg::OP_DIVI;
         vfc_pkg::ST_DIV:    cmd.op = vfc_pkg::OP_DIV;
         vfc_pkg::ST_DSTORE: cmd.op = vfc_pkg::OP_DSTORE;
         vfc_pkg::ST_ZSTORE: cmd.op = vfc_pkg::OP_ZSTORE;
         vfc_pkg::ST_TMUL:   cmd.op = vfc_pkg::OP_TMUL;
         vfc_pkg::ST_TACC:   cmd.op = vfc_pkg::OP_TACC;
         default:            cmd.op = vfc_pkg::OP_NOP;
      endcase
   end

   // counters
   always_comb begin
      mode_in = mode_ff;
      k_in    = k_ff;
      c_in    = c_ff;
      it_in   = it_ff;
      case (state_ff)
         vfc_pkg::ST_IDLE: begin
            if (accept) begin
               mode_in = req_mode;
               k_in    = '0;
               c_in    = '0;
            end
         end
         vfc_pkg::ST_RAW:  c_in = '0;
         vfc_pkg::ST_SQ:   c_in = (c_ff == 2'd2) ? 2'd0 : c_ff + 2'd1;
         vfc_pkg::ST_SQI:  it_in = '0;
         vfc_pkg::ST_SQRT: it_in = it_ff + 6'd1;
         vfc_pkg::ST_DIVI: it_in = '0;
         vfc_pkg::ST_DIV:  it_in = it_ff + 6'd1;
         vfc_pkg::ST_DSTORE: begin
            c_in = c_ff + 2'd1;
            if (c_ff == 2'd3 && !last_plane) k_in = k_ff + 3'd1;
         end
         vfc_pkg::ST_ZSTORE: if (!last_plane) k_in = k_ff + 3'd1;
         vfc_pkg::ST_TACC:   if (!last_plane) k_in = k_ff + 3'd1;
         default: ;
      endcase
   end

   `VFC_ASSERT_NEXT(a_strobe_one_cycle, clock, reset, rsp_valid, !rsp_valid)
   `VFC_ASSERT_NEXT(a_accept_busy, clock, reset, accept, busy)
   `VFC_ASSERT_IMPL(a_plane_range, clock, reset, busy,
                    k_ff < 3'(vfc_pkg::PLANE_COUNT))
   `VFC_ASSERT_IMPL(a_test_mode, clock, reset, state_ff == vfc_pkg::ST_TMUL,
                    mode_ff == vfc_pkg::MODE_SPHERE || mode_ff == vfc_pkg::MODE_BOX)

endmodule

`default_nettype wire

// File: hdl/vfc_dp.sv
// Datapath for the view frustum culling block: matrix and plane registers,
// squared-length accumulator, bit-serial square root and divider, distance unit.
// Depends on vfc_pkg.
`default_nettype none

module vfc_dp (
   input  wire                  clock,
   input  wire                  reset,
   input  vfc_pkg::dp_cmd_type  cmd,
   input  wire  [1:0]           req_mode,
   input  wire  [1:0]           req_row_index,
   input  wire  signed [31:0]   req_matrix_c0,
   input  wire  signed [31:0]   req_matrix_c1,
   input  wire  signed [31:0]   req_matrix_c2,
   input  wire  signed [31:0]   req_matrix_c3,
   input  wire  signed [31:0]   req_coord_x,
   input  wire  signed [31:0]   req_coord_y,
   input  wire  signed [31:0]   req_coord_z,
   input  wire  [30:0]          req_sphere_radius,
   input  wire  signed [31:0]   req_box_max_x,
   input  wire  signed [63:0]   req_box_max_yz,
   output vfc_pkg::dp_stat_type stat,
   output logic                 inside_res,
   output logic                 saturated
);

   logic [31:0]        mat_ff [16];
   logic [31:0]        pl_ff  [vfc_pkg::PLANE_COUNT * 4];
   logic [1:0]         mode_ff;
   logic [1:0]         row_ff;
   logic [31:0]        cap_ff [4];
   logic signed [31:0] lo_ff  [3];
   logic signed [31:0] hi_ff  [3];
   logic [30:0]        rad_ff;
   logic signed [32:0] v_ff   [4];
   logic [63:0]        len2_ff;
   logic [63:0]        sq_n_ff, sq_r_ff, sq_b_ff;
   logic [31:0]        len_ff;
   logic [48:0]        num_ff, quo_ff;
   logic [31:0]        rem_ff;
   logic signed [63:0] prod_ff [3];
   logic               sat_ff, cull_ff;

   logic signed [32:0] raw     [4];
   logic signed [32:0] vsel;
   logic [32:0]        vmag;
   logic [31:0]        sq_m;
   logic               big;
   logic [63:0]        sq_t;
   logic [32:0]        trial;
   logic               q_bit;
   logic [48:0]        q_clamp;
   logic               q_over;
   logic [31:0]        store_word;
   logic signed [49:0] dist_sum;
   logic signed [49:0] neg_rad;
   logic               plane_cull;

   // raw plane components and the shared-exponent halving
   always_comb begin
      big = 1'b0;
      for (int c = 0; c < 4; c++) begin
         if (cmd.plane[0])
            raw[c] = {mat_ff[12 + c][31], mat_ff[12 + c]}
                   - {mat_ff[{cmd.plane[2:1], 2'(c)}][31], mat_ff[{cmd.plane[2:1], 2'(c)}]};
         else
            raw[c] = {mat_ff[12 + c][31], mat_ff[12 + c]}
                   + {mat_ff[{cmd.plane[2:1], 2'(c)}][31], mat_ff[{cmd.plane[2:1], 2'(c)}]};
         if (c < 3 && !(raw[c][32] == raw[c][31] && raw[c][31:0] != 32'h8000_0000))
            big = 1'b1;
      end
   end

   assign vsel  = v_ff[cmd.comp];
   assign vmag  = vsel[32] ? 33'(-vsel) : 33'(vsel);
   assign sq_m  = vmag[31:0];
   assign sq_t  = sq_r_ff + sq_b_ff;
   assign trial = {rem_ff, num_ff[48]};
   assign q_bit = (trial >= {1'b0, len_ff});

   // clamp the quotient to the signed 32-bit range
   always_comb begin
      if (vsel[32]) begin
         q_over  = (quo_ff > 49'h0_8000_0000);
         q_clamp = q_over ? 49'h0_8000_0000 : quo_ff;
         store_word = 32'(-q_clamp[31:0]);
      end else begin
         q_over  = (quo_ff > 49'h0_7FFF_FFFF);
         q_clamp = q_over ? 49'h0_7FFF_FFFF : quo_ff;
         store_word = q_clamp[31:0];
      end
   end

   assign neg_rad = -$signed({19'd0, rad_ff});

   always_comb begin
      dist_sum = 50'(signed'(pl_ff[{cmd.plane, 2'd3}]));
      for (int c = 0; c < 3; c++)
         dist_sum = dist_sum + 50'(prod_ff[c] >>> 16);
      if (mode_ff == vfc_pkg::MODE_BOX) plane_cull = dist_sum[49];
      else                              plane_cull = (dist_sum <= neg_rad);
   end

   // control flags
   always_ff @(posedge clock) begin
      if (reset) begin
         sat_ff  <= 1'b0;
         cull_ff <= 1'b0;
      end else begin
         case (cmd.op)
            vfc_pkg::OP_CAPTURE: begin
               sat_ff  <= 1'b0;
               cull_ff <= 1'b0;
            end
            vfc_pkg::OP_DSTORE: if (q_over) sat_ff <= 1'b1;
            vfc_pkg::OP_ZSTORE: sat_ff <= 1'b1;
            vfc_pkg::OP_TACC:   if (plane_cull) cull_ff <= 1'b1;
            default: ;
         endcase
      end
   end

   // stores: zero after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 16; i++) mat_ff[i] <= '0;
         for (int i = 0; i < vfc_pkg::PLANE_COUNT * 4; i++) pl_ff[i] <= '0;
      end else begin
         case (cmd.op)
            vfc_pkg::OP_LOAD: begin
               for (int c = 0; c < 4; c++) mat_ff[{row_ff, 2'(c)}] <= cap_ff[c];
            end
            vfc_pkg::OP_DSTORE: pl_ff[{cmd.plane, cmd.comp}] <= store_word;
            vfc_pkg::OP_ZSTORE: begin
               pl_ff[{cmd.plane, 2'd0}] <= '0;
               pl_ff[{cmd.plane, 2'd1}] <= '0;
               pl_ff[{cmd.plane, 2'd2}] <= '0;
               pl_ff[{cmd.plane, 2'd3}] <= 32'h7FFF_FFFF;
            end
            default: ;
         endcase
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      case (cmd.op)
         vfc_pkg::OP_CAPTURE: begin
            mode_ff   <= req_mode;
            row_ff    <= req_row_index;
            cap_ff[0] <= req_matrix_c0;
            cap_ff[1] <= req_matrix_c1;
            cap_ff[2] <= req_matrix_c2;
            cap_ff[3] <= req_matrix_c3;
            lo_ff[0]  <= req_coord_x;
            lo_ff[1]  <= req_coord_y;
            lo_ff[2]  <= req_coord_z;
            hi_ff[0]  <= req_box_max_x;
            hi_ff[1]  <= req_box_max_yz[63:32];
            hi_ff[2]  <= req_box_max_yz[31:0];
            rad_ff    <= req_sphere_radius;
         end
         vfc_pkg::OP_RAW: begin
            for (int c = 0; c < 4; c++) v_ff[c] <= big ? (raw[c] >>> 1) : raw[c];
            len2_ff <= '0;
         end
         vfc_pkg::OP_SQ: len2_ff <= len2_ff + 64'(sq_m * sq_m);
         vfc_pkg::OP_SQI: begin
            sq_n_ff <= len2_ff;
            sq_r_ff <= '0;
            sq_b_ff <= 64'h4000_0000_0000_0000;
         end
         vfc_pkg::OP_SQRT: begin
            if (sq_n_ff >= sq_t) begin
               sq_n_ff <= sq_n_ff - sq_t;
               sq_r_ff <= (sq_r_ff >> 1) + sq_b_ff;
            end else begin
               sq_r_ff <= sq_r_ff >> 1;
            end
            sq_b_ff <= sq_b_ff >> 2;
         end
         vfc_pkg::OP_DIVI: begin
            len_ff <= sq_r_ff[31:0];
            num_ff <= {vmag, 16'd0};
            rem_ff <= '0;
            quo_ff <= '0;
         end
         vfc_pkg::OP_DIV: begin
            rem_ff <= q_bit ? 32'(trial - {1'b0, len_ff}) : trial[31:0];
            quo_ff <= {quo_ff[47:0], q_bit};
            num_ff <= {num_ff[47:0], 1'b0};
         end
         vfc_pkg::OP_TMUL: begin
            for (int c = 0; c < 3; c++) begin
               if (mode_ff == vfc_pkg::MODE_BOX && !pl_ff[{cmd.plane, 2'(c)}][31])
                  prod_ff[c] <= signed'(pl_ff[{cmd.plane, 2'(c)}]) * hi_ff[c];
               else
                  prod_ff[c] <= signed'(pl_ff[{cmd.plane, 2'(c)}]) * lo_ff[c];
            end
         end
         default: ;
      endcase
   end

   // DIVI reads the length straight from the root register
   assign stat.len_zero = (sq_r_ff == 64'd0);
   assign inside_res    = !cull_ff;
   assign saturated     = sat_ff;

endmodule

`default_nettype wire

// File: hdl/view_frustum_cull_test.sv
// Top level of the view frustum culling block: sequencer plus datapath.
// Depends on vfc_pkg, vfc_ctrl and vfc_dp.
//
// Usage: drive the req_ ports and raise start; a transaction is taken at a
// rising edge where start is high and busy is low. Each transaction returns
// exactly one response: rsp_valid is high for one cycle with rsp_inside_res
// and rsp_saturated, and the response is taken at the edge ending that cycle.
// The receiver cannot stall; busy stays high until the response has gone.
// Sequence from the accepting edge to the response cycle:
//   load row   : the LOAD state, then DONE
//   sphere/box : a TMUL (multiply) state and a TACC (sum) state per plane
//   build      : per plane, RAW and SQ form the squared length and SQRT
//                runs the 32-step bit-serial square root, then each
//                component runs the 49-step serial divider
// A new transaction can be taken in the cycle after the response cycle.
// Reset (synchronous) clears the matrix and plane stores to zero and
// returns the sequencer to idle; no clearing pass is needed.
`default_nettype none

module view_frustum_cull_test (
   input  wire                clock,
   input  wire                reset,
   input  wire                start,
   output logic               busy,
   input  wire  [1:0]         req_mode,
   input  wire  [1:0]         req_row_index,
   input  wire  signed [31:0] req_matrix_c0,
   input  wire  signed [31:0] req_matrix_c1,
   input  wire  signed [31:0] req_matrix_c2,
   input  wire  signed [31:0] req_matrix_c3,
   input  wire  signed [31:0] req_coord_x,
   input  wire  signed [31:0] req_coord_y,
   input  wire  signed [31:0] req_coord_z,
   input  wire  [30:0]        req_sphere_radius,
   input  wire  signed [31:0] req_box_max_x,
   input  wire  signed [63:0] req_box_max_yz,
   output logic               rsp_valid,
   output logic               rsp_inside_res,
   output logic               rsp_saturated
);

   vfc_pkg::dp_cmd_type  cmd;
   vfc_pkg::dp_stat_type stat;

   vfc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_mode  (req_mode),
      .stat      (stat),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd)
   );

   vfc_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .req_mode          (req_mode),
      .req_row_index     (req_row_index),
      .req_matrix_c0     (req_matrix_c0),
      .req_matrix_c1     (req_matrix_c1),
      .req_matrix_c2     (req_matrix_c2),
      .req_matrix_c3     (req_matrix_c3),
      .req_coord_x       (req_coord_x),
      .req_coord_y       (req_coord_y),
      .req_coord_z       (req_coord_z),
      .req_sphere_radius (req_sphere_radius),
      .req_box_max_x     (req_box_max_x),
      .req_box_max_yz    (req_box_max_yz),
      .stat              (stat),
      .inside_res        (rsp_inside_res),
      .saturated         (rsp_saturated)
   );

endmodule

`default_nettype wire

// File: sim/view_frustum_cull_test_tb.sv
// Self-checking bench for view_frustum_cull_test: a directed table, then random transactions.
// Depends on vfc_pkg and the view_frustum_cull_test top level.
`default_nettype none

module view_frustum_cull_test_tb;

   typedef struct {
      logic [1:0]         mode;
      logic [1:0]         row;
      logic signed [31:0] m [4];
      logic signed [31:0] cx, cy, cz;
      logic [30:0]        rad;
      logic signed [31:0] bx;
      logic signed [63:0] byz;
      bit                 typed;
      bit                 e_in, e_sat;
   } cull_txn_type;

   typedef struct {
      bit in_res;
      bit sat;
   } cull_rsp_type;

   logic               clock = 0;
   logic               reset = 1;
   logic               start = 0;
   logic               busy;
   logic [1:0]         req_mode = 0;
   logic [1:0]         req_row_index = 0;
   logic signed [31:0] req_matrix_c0 = 0, req_matrix_c1 = 0, req_matrix_c2 = 0;
   logic signed [31:0] req_matrix_c3 = 0;
   logic signed [31:0] req_coord_x = 0, req_coord_y = 0, req_coord_z = 0;
   logic [30:0]        req_sphere_radius = 0;
   logic signed [31:0] req_box_max_x = 0;
   logic signed [63:0] req_box_max_yz = 0;
   logic               rsp_valid, rsp_inside_res, rsp_saturated;

   view_frustum_cull_test i_dut (.*);

   always #6 clock = ~clock;

   // predictor state
   logic signed [31:0] mat_q [16];
   logic signed [31:0] pln_q [24];
   cull_rsp_type       pending_rsp [$];
   int                 err_count, idle_cycles, acc_count, rsp_count;
   int                 mode_seen [4];
   bit                 calm;

   function automatic longint floor16(longint v);
      return v >>> 16;
   endfunction

   function automatic longint magn(longint v);
      return v < 0 ? -v : v;
   endfunction

   function automatic longint int_sqrt(longint unsigned n);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
         if (n >= r + b) begin
            n -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   function automatic logic [31:0] scale_comp(longint v, longint unsigned len, ref bit sat);
      longint unsigned q;
      q = (longint'(magn(v)) << 16) / len;
      if (v < 0) begin
         if (q > 64'h8000_0000) begin
            sat = 1;
            q = 64'h8000_0000;
         end
         return 32'(-q);
      end
      if (q > 64'h7FFF_FFFF) begin
         sat = 1;
         q = 64'h7FFF_FFFF;
      end
      return 32'(q);
   endfunction

   function automatic bit extract_planes();
      bit sat;
      longint v [4];
      bit big;
      longint unsigned len2, len;
      int src;
      sat = 0;
      for (int k = 0; k < vfc_pkg::PLANE_COUNT; k++) begin
         src = (k >> 1) & 3;
         big = 0;
         len2 = 0;
         for (int c = 0; c < 4; c++) begin
            v[c] = (k & 1) ? longint'(mat_q[12+c]) - longint'(mat_q[src*4+c])
                           : longint'(mat_q[12+c]) + longint'(mat_q[src*4+c]);
            if (c < 3 && magn(v[c]) >= 64'h8000_0000) big = 1;
         end
         if (big)
            for (int c = 0; c < 4; c++) v[c] = v[c] >>> 1;
         for (int c = 0; c < 3; c++) len2 += longint'(magn(v[c])) * longint'(magn(v[c]));
         len = int_sqrt(len2);
         if (len == 0) begin
            sat = 1;
            for (int c = 0; c < 3; c++) pln_q[k*4+c] = 0;
            pln_q[k*4+3] = 32'h7FFF_FFFF;
         end else begin
            for (int c = 0; c < 4; c++) pln_q[k*4+c] = scale_comp(v[c], len, sat);
         end
      end
      return sat;
   endfunction

   function automatic longint plane_distance(int k, longint p [3]);
      longint d;
      d = pln_q[k*4+3];
      for (int c = 0; c < 3; c++) d += floor16(longint'(pln_q[k*4+c]) * p[c]);
      return d;
   endfunction

   function automatic cull_rsp_type predict_cull(cull_txn_type t);
      cull_rsp_type r;
      longint p [3], lo [3], hi [3];
      r.in_res = 1;
      r.sat = 0;
      case (t.mode)
         vfc_pkg::MODE_LOAD: begin
            for (int c = 0; c < 4; c++) mat_q[t.row*4+c] = t.m[c];
         end
         vfc_pkg::MODE_BUILD: r.sat = extract_planes();
         vfc_pkg::MODE_SPHERE: begin
            p[0] = t.cx; p[1] = t.cy; p[2] = t.cz;
            for (int k = 0; k < vfc_pkg::PLANE_COUNT; k++)
               if (plane_distance(k, p) <= -longint'(t.rad)) begin
                  r.in_res = 0;
                  break;
               end
         end
         default: begin
            lo[0] = t.cx; lo[1] = t.cy; lo[2] = t.cz;
            hi[0] = t.bx;
            hi[1] = longint'($signed(t.byz[63:32]));
            hi[2] = longint'($signed(t.byz[31:0]));
            for (int k = 0; k < vfc_pkg::PLANE_COUNT; k++) begin
               for (int c = 0; c < 3; c++) p[c] = pln_q[k*4+c] >= 0 ? hi[c] : lo[c];
               if (plane_distance(k, p) < 0) begin
                  r.in_res = 0;
                  break;
               end
            end
         end
      endcase
      return r;
   endfunction

   task automatic report_mismatch(string what);
      err_count++;
      $display("mismatch: %s", what);
   endtask

   // response checker and watchdog
   always @(posedge clock) begin
      cull_rsp_type e;
      if (!reset) begin
         idle_cycles <= (start && !busy) || rsp_valid ? 0 : idle_cycles + 1;
         if (idle_cycles > 20000) begin
            $display("watchdog expired");
            $display("TB_ERROR");
            $finish;
         end
         if (rsp_valid) begin
            rsp_count++;
            if (pending_rsp.size() == 0) begin
               report_mismatch("response with nothing outstanding");
            end else begin
               e = pending_rsp.pop_front();
               if (rsp_inside_res !== e.in_res)
                  report_mismatch($sformatf("inside_res %b want %b", rsp_inside_res, e.in_res));
               if (rsp_saturated !== e.sat)
                  report_mismatch($sformatf("saturated %b want %b", rsp_saturated, e.sat));
            end
         end
      end
   end

   function automatic logic [31:0] rnd_word();
      case ($urandom_range(0, 5))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'($signed($urandom_range(0, 8 << 16)) - (4 << 16));
         3: return 32'($signed($urandom_range(0, 2 << 16)) - (1 << 16));
         default: return $urandom;
      endcase
   endfunction

   function automatic cull_txn_type rnd_txn(logic [1:0] mode);
      cull_txn_type t;
      t.mode = mode;
      t.row = 2'($urandom_range(0, 3));
      for (int c = 0; c < 4; c++) t.m[c] = rnd_word();
      t.cx = rnd_word(); t.cy = rnd_word(); t.cz = rnd_word();
      t.rad = $urandom_range(0, 3) == 0 ? 31'($urandom) : 31'($urandom_range(0, 4 << 16));
      t.bx = rnd_word();
      t.byz = {rnd_word(), rnd_word()};
      t.typed = 0;
      return t;
   endfunction

   // drive one transaction and hold until it is taken; start stays high
   // between transactions and drops only for an idle gap
   task automatic send_txn(cull_txn_type t);
      cull_rsp_type p;
      int gap;
      if (!calm && $urandom_range(0, 3) == 0) begin
         gap = int'($urandom_range(1, 13));
         start <= 0;
         repeat (gap) @(negedge clock);
      end
      req_mode <= t.mode;
      req_row_index <= t.row;
      req_matrix_c0 <= t.m[0]; req_matrix_c1 <= t.m[1];
      req_matrix_c2 <= t.m[2]; req_matrix_c3 <= t.m[3];
      req_coord_x <= t.cx; req_coord_y <= t.cy; req_coord_z <= t.cz;
      req_sphere_radius <= t.rad;
      req_box_max_x <= t.bx;
      req_box_max_yz <= t.byz;
      start <= 1;
      do @(posedge clock); while (busy);
      p = predict_cull(t);
      if (t.typed && (p.in_res != t.e_in || p.sat != t.e_sat))
         report_mismatch("directed row disagrees with predictor");
      pending_rsp.push_back(p);
      acc_count++;
      mode_seen[t.mode]++;
      @(negedge clock);
   endtask

   cull_txn_type dir_tab [$];

   function automatic cull_txn_type row_of(logic [1:0] mode, logic [1:0] row,
         logic [31:0] a, logic [31:0] b, logic [31:0] c, logic [31:0] d,
         logic [30:0] rad, bit typed, bit ein, bit esat);
      cull_txn_type t;
      t.mode = mode; t.row = row;
      t.m[0] = a; t.m[1] = b; t.m[2] = c; t.m[3] = d;
      t.cx = a; t.cy = b; t.cz = c; t.rad = rad;
      t.bx = d; t.byz = {b, c};
      t.typed = typed; t.e_in = ein; t.e_sat = esat;
      return t;
   endfunction

   initial begin
      cull_txn_type t;
      int r;
      logic [1:0] m;
      // before any build: radius 0 is culled, boxes kept, zero matrix saturates
      dir_tab.push_back(row_of(vfc_pkg::MODE_SPHERE, 0, 0, 0, 0, 0, 0, 1, 0, 0));
      dir_tab.push_back(row_of(vfc_pkg::MODE_SPHERE, 0, 0, 0, 0, 0, 1, 1, 1, 0));
      dir_tab.push_back(row_of(vfc_pkg::MODE_BOX, 0, 32'h8000_0000, 0, 0, 32'h7FFF_FFFF,
                               0, 1, 1, 0));
      dir_tab.push_back(row_of(vfc_pkg::MODE_BUILD, 0, 0, 0, 0, 0, 0, 1, 1, 1));
      dir_tab.push_back(row_of(vfc_pkg::MODE_SPHERE, 0, 32'h8000_0000, 32'h8000_0000,
                               32'h8000_0000, 0, 0, 1, 1, 0));
      // identity matrix
      dir_tab.push_back(row_of(vfc_pkg::MODE_LOAD, 0, 32'h10000, 0, 0, 0, 0, 1, 1, 0));
      dir_tab.push_back(row_of(vfc_pkg::MODE_LOAD, 1, 0, 32'h10000, 0, 0, 0, 1, 1, 0));
      dir_tab.push_back(row_of(vfc_pkg::MODE_LOAD, 2, 0, 0, 32'h10000, 0, 0, 1, 1, 0));
      dir_tab.push_back(row_of(vfc_pkg::MODE_LOAD, 3, 0, 0, 0, 32'h10000, 0, 1, 1, 0));
      dir_tab.push_back(row_of(vfc_pkg::MODE_BUILD, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      dir_tab.push_back(row_of(vfc_pkg::MODE_SPHERE, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      dir_tab.push_back(row_of(vfc_pkg::MODE_SPHERE, 0, 32'h30000, 0, 0, 0, 31'h10000,
                               0, 0, 0));
      dir_tab.push_back(row_of(vfc_pkg::MODE_SPHERE, 0, 32'h7FFF_FFFF, 0, 0, 0,
                               31'h7FFF_FFFF, 0, 0, 0));
      dir_tab.push_back(row_of(vfc_pkg::MODE_BOX, 0, 32'hFFFF_0000, 0, 0, 32'h10000,
                               0, 0, 0, 0));
      dir_tab.push_back(row_of(vfc_pkg::MODE_BOX, 0, 32'h50000, 32'h50000, 32'h50000,
                               32'h60000, 0, 0, 0, 0));
      // extreme rows: large raw components take the halving path and clamp
      dir_tab.push_back(row_of(vfc_pkg::MODE_LOAD, 0, 32'h8000_0000, 32'h8000_0000,
                               32'h8000_0000, 32'h8000_0000, 0, 1, 1, 0));
      dir_tab.push_back(row_of(vfc_pkg::MODE_LOAD, 3, 32'h8000_0000, 32'h7FFF_FFFF,
                               32'h8000_0000, 32'h7FFF_FFFF, 0, 1, 1, 0));
      dir_tab.push_back(row_of(vfc_pkg::MODE_BUILD, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      dir_tab.push_back(row_of(vfc_pkg::MODE_BOX, 0, 32'h8000_0000, 32'h8000_0000,
                               32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 0, 0));
      dir_tab.push_back(row_of(vfc_pkg::MODE_SPHERE, 0, 32'h7FFF_FFFF, 32'h8000_0000,
                               32'h7FFF_FFFF, 0, 31'h7FFF_FFFF, 0, 0, 0));
      // tiny normal: big w over a length of one clamps
      dir_tab.push_back(row_of(vfc_pkg::MODE_LOAD, 3, 1, 0, 0, 32'h7FFF_FFFF, 0, 1, 1, 0));
      dir_tab.push_back(row_of(vfc_pkg::MODE_LOAD, 0, 0, 0, 0, 32'h8000_0000, 0, 1, 1, 0));
      dir_tab.push_back(row_of(vfc_pkg::MODE_BUILD, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      dir_tab.push_back(row_of(vfc_pkg::MODE_BOX, 0, 0, 0, 0, 0, 0, 0, 0, 0));

      for (int i = 0; i < 16; i++) mat_q[i] = 0;
      for (int i = 0; i < 24; i++) pln_q[i] = 0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      foreach (dir_tab[i]) send_txn(dir_tab[i]);

      // random sequences: load the four rows, build, then a burst of tests; or a short run of random modes
      r = 0;
      while (r < 400) begin
         calm = r > 340;
         if ($urandom_range(0, 4) != 0) begin
            for (int i = 0; i < 4; i++) begin
               t = rnd_txn(vfc_pkg::MODE_LOAD);
               t.row = 2'(i);
               send_txn(t);
            end
            send_txn(rnd_txn(vfc_pkg::MODE_BUILD));
            r += 5;
            repeat ($urandom_range(4, 14)) begin
               send_txn(rnd_txn($urandom_range(0, 1) ? vfc_pkg::MODE_SPHERE
                                                     : vfc_pkg::MODE_BOX));
               r++;
            end
         end else begin
            repeat ($urandom_range(1, 6)) begin
               m = 2'($urandom_range(0, 3));
               send_txn(rnd_txn(m));
               r++;
            end
         end
      end
      start <= 0;

      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      $display("covered %0d transactions (load %0d, build %0d, sphere %0d, box %0d)",
               acc_count, mode_seen[0], mode_seen[1], mode_seen[2], mode_seen[3]);
      $display("%0d responses checked, %0d mismatches", rsp_count, err_count);
      if (err_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end
endmodule

`default_nettype wire
